/* rtl/mbrf_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the CRC-16 byte update for the Modbus read request framer.
// No dependencies; every other file refers to this package by scoped names.
package mbrf_pkg;

    localparam int CfgW       = 16;
    localparam int FrameBytes = 8;
    localparam int CntW       = $clog2(FrameBytes);

    // Configuration register indexes.
    localparam logic [1:0] CFG_FUNCTION_CODE  = 2'd0;
    localparam logic [1:0] CFG_START_ADDRESS  = 2'd1;
    localparam logic [1:0] CFG_REGISTER_COUNT = 2'd2;
    localparam logic [1:0] CFG_LAST_SLAVE     = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [7:0]  RstFunctionCode  = 8'h04;
    localparam logic [15:0] RstStartAddress  = 16'h0003;
    localparam logic [15:0] RstRegisterCount = 16'h0002;
    localparam logic [7:0]  RstLastSlave     = 8'd6;

    localparam logic [7:0]  MaxSlave = 8'd247;
    localparam logic [7:0]  MinSlave = 8'd1;
    localparam logic [15:0] CrcInit  = 16'hFFFF;
    localparam logic [15:0] CrcPoly  = 16'hA001;

    // Byte positions within a request frame, in send order.
    localparam logic [CntW-1:0] BYTE_SLAVE    = 3'd0;
    localparam logic [CntW-1:0] BYTE_FUNCTION = 3'd1;
    localparam logic [CntW-1:0] BYTE_ADDR_HI  = 3'd2;
    localparam logic [CntW-1:0] BYTE_ADDR_LO  = 3'd3;
    localparam logic [CntW-1:0] BYTE_CNT_HI   = 3'd4;
    localparam logic [CntW-1:0] BYTE_CNT_LO   = 3'd5;
    localparam logic [CntW-1:0] BYTE_CRC_LO   = 3'd6;
    localparam logic [CntW-1:0] BYTE_CRC_HI   = 3'd7;

    typedef struct packed {
        logic [7:0]  function_code;
        logic [15:0] start_address;
        logic [15:0] register_count;
        logic [7:0]  last_slave;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  slave;
        logic [7:0]  function_code;
        logic [15:0] start_address;
        logic [15:0] register_count;
    } t_frame;

    // One byte of CRC-16/Modbus: eight shift steps, LSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/modbus_read_request_framer.sv */
`timescale 1ns / 1ps
// Modbus RTU read request framer, top level. The first byte of a frame is registered in
// the frame register, then in the serializer's output register; i_tx_ready can stall it.
// A poll of 1 yields eight bytes, one per cycle while i_tx_ready is high; a poll of 0 is
// taken but yields none. A new poll waits until no frame is held or its last byte leaves.
// Reset (synchronous, active low) restores the register defaults and restarts at slave 1.
module modbus_read_request_framer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [mbrf_pkg::CfgW-1:0] i_cfg_data,
    input  logic                      i_poll_valid,
    output logic                      o_poll_ready,
    input  logic                      i_poll,
    output logic                      o_tx_valid,
    input  logic                      i_tx_ready,
    output logic [7:0]                o_tx_byte,
    output logic                      o_frame_last,
    output logic [7:0]                o_target_slave
);

    mbrf_pkg::t_cfg   cfg;
    mbrf_pkg::t_frame frm;
    logic             frm_valid;
    logic             pop;

    mbrf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mbrf_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_poll_valid (i_poll_valid),
        .o_poll_ready (o_poll_ready),
        .i_poll       (i_poll),
        .i_pop        (pop),
        .o_frm_valid  (frm_valid),
        .o_frm        (frm)
    );

    mbrf_ser u_ser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frm_valid    (frm_valid),
        .i_frm          (frm),
        .o_pop          (pop),
        .o_tx_valid     (o_tx_valid),
        .i_tx_ready     (i_tx_ready),
        .o_tx_byte      (o_tx_byte),
        .o_frame_last   (o_frame_last),
        .o_target_slave (o_target_slave)
    );

endmodule

/* rtl/mbrf_cfg.sv */
`timescale 1ns / 1ps
// Configuration registers of the Modbus read request framer.
// Depends on mbrf_pkg for register indexes, reset values and t_cfg.
module mbrf_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [mbrf_pkg::CfgW-1:0] i_cfg_data,
    output mbrf_pkg::t_cfg            o_cfg
);

    mbrf_pkg::t_cfg r_cfg;
    mbrf_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                mbrf_pkg::CFG_FUNCTION_CODE:  n_cfg.function_code  = i_cfg_data[7:0];
                mbrf_pkg::CFG_START_ADDRESS:  n_cfg.start_address  = i_cfg_data;
                mbrf_pkg::CFG_REGISTER_COUNT: n_cfg.register_count = i_cfg_data;
                mbrf_pkg::CFG_LAST_SLAVE:     n_cfg.last_slave     = i_cfg_data[7:0];
                default:                      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.function_code  <= mbrf_pkg::RstFunctionCode;
            r_cfg.start_address  <= mbrf_pkg::RstStartAddress;
            r_cfg.register_count <= mbrf_pkg::RstRegisterCount;
            r_cfg.last_slave     <= mbrf_pkg::RstLastSlave;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/mbrf_frame.sv */
`timescale 1ns / 1ps
// Input register of the framer: takes poll items, picks the slave and holds one frame.
// Depends on mbrf_pkg for t_cfg, t_frame and the slave limits.
module mbrf_frame (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mbrf_pkg::t_cfg   i_cfg,
    input  logic             i_poll_valid,
    output logic             o_poll_ready,
    input  logic             i_poll,
    input  logic             i_pop,
    output logic             o_frm_valid,
    output mbrf_pkg::t_frame o_frm
);

    logic             r_valid;
    logic             n_valid;
    logic [7:0]       r_next_slave;
    logic [7:0]       n_next_slave;
    mbrf_pkg::t_frame r_frm;
    logic [7:0]       lim;
    logic [7:0]       slave;
    logic             take;

    assign o_poll_ready = !r_valid || i_pop;
    assign take         = i_poll_valid && o_poll_ready && i_poll;

    always_comb begin
        // A last slave of zero acts as one; above the Modbus limit it saturates.
        if (i_cfg.last_slave < mbrf_pkg::MinSlave) begin
            lim = mbrf_pkg::MinSlave;
        end else if (i_cfg.last_slave > mbrf_pkg::MaxSlave) begin
            lim = mbrf_pkg::MaxSlave;
        end else begin
            lim = i_cfg.last_slave;
        end
        // A stale slave number (for example after last_slave was lowered) restarts at one.
        if (r_next_slave < mbrf_pkg::MinSlave || r_next_slave > lim) begin
            slave = mbrf_pkg::MinSlave;
        end else begin
            slave = r_next_slave;
        end

        n_valid      = r_valid;
        n_next_slave = r_next_slave;
        if (i_pop) begin
            n_valid = 1'b0;
        end
        if (take) begin
            n_valid      = 1'b1;
            n_next_slave = (slave >= lim) ? mbrf_pkg::MinSlave : slave + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_next_slave <= mbrf_pkg::MinSlave;
        end else begin
            r_valid      <= n_valid;
            r_next_slave <= n_next_slave;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_frm.slave          <= slave;
            r_frm.function_code  <= i_cfg.function_code;
            r_frm.start_address  <= i_cfg.start_address;
            r_frm.register_count <= i_cfg.register_count;
        end
    end

    assign o_frm_valid = r_valid;
    assign o_frm       = r_frm;

`ifndef SYNTH
    a_slave_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_frm.slave >= mbrf_pkg::MinSlave && r_frm.slave <= mbrf_pkg::MaxSlave))
        else $error("held frame addresses a slave outside 1..247");
    a_next_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_slave >= mbrf_pkg::MinSlave && r_next_slave <= mbrf_pkg::MaxSlave)
        else $error("next slave register left the valid range");
`endif

endmodule

/* rtl/mbrf_ser.sv */
`timescale 1ns / 1ps
// Serializer: one byte of the held frame per cycle unless stalled; folds each header byte
// into the running CRC. Depends on mbrf_pkg for t_frame, byte positions and crc16_byte.
module mbrf_ser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_frm_valid,
    input  mbrf_pkg::t_frame i_frm,
    output logic             o_pop,
    output logic             o_tx_valid,
    input  logic             i_tx_ready,
    output logic [7:0]       o_tx_byte,
    output logic             o_frame_last,
    output logic [7:0]       o_target_slave
);

    logic [mbrf_pkg::CntW-1:0] r_cnt;
    logic [mbrf_pkg::CntW-1:0] n_cnt;
    logic [15:0]               r_crc;
    logic [15:0]               crc_base;
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic [7:0]                r_out_byte;
    logic                      r_out_last;
    logic [7:0]                r_out_slave;
    logic [7:0]                cur_byte;
    logic                      adv;

    // The output register moves on when it is empty or its item is taken.
    assign adv   = i_frm_valid && (!r_out_valid || i_tx_ready);
    assign o_pop = adv && (r_cnt == mbrf_pkg::BYTE_CRC_HI);

    always_comb begin
        case (r_cnt)
            mbrf_pkg::BYTE_SLAVE:    cur_byte = i_frm.slave;
            mbrf_pkg::BYTE_FUNCTION: cur_byte = i_frm.function_code;
            mbrf_pkg::BYTE_ADDR_HI:  cur_byte = i_frm.start_address[15:8];
            mbrf_pkg::BYTE_ADDR_LO:  cur_byte = i_frm.start_address[7:0];
            mbrf_pkg::BYTE_CNT_HI:   cur_byte = i_frm.register_count[15:8];
            mbrf_pkg::BYTE_CNT_LO:   cur_byte = i_frm.register_count[7:0];
            mbrf_pkg::BYTE_CRC_LO:   cur_byte = r_crc[7:0];
            mbrf_pkg::BYTE_CRC_HI:   cur_byte = r_crc[15:8];
            default:                 cur_byte = 8'h00;
        endcase
        crc_base = (r_cnt == mbrf_pkg::BYTE_SLAVE) ? mbrf_pkg::CrcInit : r_crc;

        n_cnt       = adv ? r_cnt + 1'b1 : r_cnt;
        n_out_valid = r_out_valid;
        if (adv) begin
            n_out_valid = 1'b1;
        end else if (i_tx_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= mbrf_pkg::BYTE_SLAVE;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte  <= cur_byte;
            r_out_last  <= (r_cnt == mbrf_pkg::BYTE_CRC_HI);
            r_out_slave <= i_frm.slave;
            if (r_cnt < mbrf_pkg::BYTE_CRC_LO) begin
                r_crc <= mbrf_pkg::crc16_byte(crc_base, cur_byte);
            end
        end
    end

    assign o_tx_valid     = r_out_valid;
    assign o_tx_byte      = r_out_byte;
    assign o_frame_last   = r_out_last;
    assign o_target_slave = r_out_slave;

`ifndef SYNTH
    a_frame_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != mbrf_pkg::BYTE_SLAVE) |-> i_frm_valid)
        else $error("frame released before its last byte was sent");
    a_first_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_cnt == mbrf_pkg::BYTE_SLAVE) |=> (r_out_byte == r_out_slave && !r_out_last))
        else $error("first frame byte is not the slave address");
    a_last_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_cnt == mbrf_pkg::BYTE_SLAVE && r_out_last && r_out_valid))
        else $error("frame end and byte counter out of step");
`endif

endmodule

/* tb/tb_modbus_read_request_framer.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the Modbus RTU read request framer: directed and random polls,
// random settings, random stalls on both handshakes. Depends on mbrf_pkg and the framer RTL.
module tb_modbus_read_request_framer;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
        logic [7:0] slave;
    } t_frame_byte;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [1:0]                i_cfg_index = mbrf_pkg::CFG_FUNCTION_CODE;
    logic [mbrf_pkg::CfgW-1:0] i_cfg_data = '0;
    logic                      i_poll_valid = 1'b0;
    logic                      o_poll_ready;
    logic                      i_poll = 1'b0;
    logic                      o_tx_valid;
    logic                      i_tx_ready = 1'b0;
    logic [7:0]                o_tx_byte;
    logic                      o_frame_last;
    logic [7:0]                o_target_slave;

    modbus_read_request_framer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_poll_valid   (i_poll_valid),
        .o_poll_ready   (o_poll_ready),
        .i_poll         (i_poll),
        .o_tx_valid     (o_tx_valid),
        .i_tx_ready     (i_tx_ready),
        .o_tx_byte      (o_tx_byte),
        .o_frame_last   (o_frame_last),
        .o_target_slave (o_target_slave)
    );

    // Shadow copy of the registers and the slave counter.
    logic [7:0]  sh_func  = mbrf_pkg::RstFunctionCode;
    logic [15:0] sh_start = mbrf_pkg::RstStartAddress;
    logic [15:0] sh_count = mbrf_pkg::RstRegisterCount;
    logic [7:0]  sh_last  = mbrf_pkg::RstLastSlave;
    logic [7:0]  next_addr = mbrf_pkg::MinSlave;

    logic        polls_pending[$];
    t_frame_byte frame_bytes_due[$];
    t_frame_byte due_byte;
    int          mismatch_count = 0;
    int          items_queued = 0;

    bit poll_fire = 1'b0;
    bit tx_fire = 1'b0;
    bit sender_eager = 1'b0;
    bit rx_eager = 1'b0;
    int poll_gap = 0;
    int rx_gap = 0;
    int hold_left = 0;
    int hold_requests = 0;
    int hold_served = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap(input bit eager);
        int r;
        r = $urandom_range(0, 99);
        if (eager || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 25);
    endfunction

    function automatic logic [15:0] header_crc(input logic [47:0] hdr);
        logic [15:0] crc;
        crc = 16'hFFFF;
        for (int i = 0; i < 6; i++) begin
            crc = crc ^ {8'h00, hdr[47 - 8 * i -: 8]};
            for (int b = 0; b < 8; b++)
                crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
        end
        return crc;
    endfunction

    // Works out the eight bytes of the frame that an accepted poll causes.
    task automatic frame_predict(input logic poll);
        logic [7:0]  lim;
        logic [7:0]  slave;
        logic [15:0] crc;
        logic [63:0] frame;
        t_frame_byte fb;
        if (!poll)
            return;
        lim = sh_last;
        if (lim < mbrf_pkg::MinSlave)
            lim = mbrf_pkg::MinSlave;
        if (lim > mbrf_pkg::MaxSlave)
            lim = mbrf_pkg::MaxSlave;
        // A counter left beyond a lowered limit restarts at slave one.
        slave = next_addr;
        if (slave < mbrf_pkg::MinSlave || slave > lim)
            slave = mbrf_pkg::MinSlave;
        crc = header_crc({slave, sh_func, sh_start, sh_count});
        frame = {slave, sh_func, sh_start, sh_count, crc[7:0], crc[15:8]};
        for (int k = 0; k < mbrf_pkg::FrameBytes; k++) begin
            fb.tx_byte = frame[63 - 8 * k -: 8];
            fb.last    = (k == mbrf_pkg::FrameBytes - 1);
            fb.slave   = slave;
            frame_bytes_due.push_back(fb);
        end
        next_addr = (slave >= lim) ? mbrf_pkg::MinSlave : slave + 8'd1;
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatch_count++;
        $display("mismatch at %0t: %s got 0x%02h, expected 0x%02h", $realtime, what, got, want);
    endtask

    // Poll driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_poll_valid <= 1'b0;
        end else if (i_poll_valid && !poll_fire) begin
            // Hold the item until it is taken.
        end else if (poll_gap > 0) begin
            poll_gap = poll_gap - 1;
            i_poll_valid <= 1'b0;
        end else if (polls_pending.size() > 0) begin
            i_poll_valid <= 1'b1;
            i_poll <= polls_pending.pop_front();
            poll_gap = pick_gap(sender_eager);
        end else begin
            i_poll_valid <= 1'b0;
        end
    end

    // Byte receiver with random stalls and an occasional long hold-off.
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_served + 1;
            hold_left = 80;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_tx_ready <= 1'b0;
        end else begin
            if (tx_fire && rx_gap == 0)
                rx_gap = pick_gap(rx_eager);
            if (rx_gap > 0) begin
                rx_gap = rx_gap - 1;
                i_tx_ready <= 1'b0;
            end else begin
                i_tx_ready <= 1'b1;
            end
        end
    end

    // Monitor: checks each byte against the oldest expectation, then predicts new polls.
    always @(posedge i_clk) begin
        tx_fire = 1'b0;
        poll_fire = 1'b0;
        if (i_rst_n) begin
            if (o_tx_valid && i_tx_ready) begin
                tx_fire = 1'b1;
                if (frame_bytes_due.size() == 0) begin
                    report_mismatch("unexpected byte", o_tx_byte, 8'h00);
                end else begin
                    due_byte = frame_bytes_due.pop_front();
                    if (o_tx_byte !== due_byte.tx_byte)
                        report_mismatch("tx_byte", o_tx_byte, due_byte.tx_byte);
                    if (o_frame_last !== due_byte.last)
                        report_mismatch("frame_last", {7'd0, o_frame_last},
                                        {7'd0, due_byte.last});
                    if (o_target_slave !== due_byte.slave)
                        report_mismatch("target_slave", o_target_slave, due_byte.slave);
                end
            end
            if (i_poll_valid && o_poll_ready) begin
                poll_fire = 1'b1;
                frame_predict(i_poll);
            end
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [mbrf_pkg::CfgW-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            mbrf_pkg::CFG_FUNCTION_CODE:  sh_func  = data[7:0];
            mbrf_pkg::CFG_START_ADDRESS:  sh_start = data;
            mbrf_pkg::CFG_REGISTER_COUNT: sh_count = data;
            mbrf_pkg::CFG_LAST_SLAVE:     sh_last  = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_polls(input logic [15:0] pattern, input int n);
        for (int i = n - 1; i >= 0; i--) begin
            polls_pending.push_back(pattern[i]);
            items_queued++;
        end
    endtask

    // Returns once every poll is taken and every byte has arrived, plus a short tail.
    task automatic wait_drained();
        while (polls_pending.size() != 0 || i_poll_valid || frame_bytes_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_last_slave();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd247;
            3:       return 8'd248;
            4:       return 8'd255;
            8:       return 8'($urandom_range(11, 246));
            9:       return 8'($urandom);
            default: return 8'($urandom_range(2, 10));
        endcase
    endfunction

    task automatic random_settings();
        logic [7:0] fc;
        logic [7:0] upper;
        case ($urandom_range(0, 3))
            0:       fc = 8'h00;
            1:       fc = 8'hFF;
            default: fc = 8'($urandom);
        endcase
        upper = 8'($urandom);
        cfg_write(mbrf_pkg::CFG_FUNCTION_CODE, {upper, fc});
        cfg_write(mbrf_pkg::CFG_START_ADDRESS, pick_word());
        cfg_write(mbrf_pkg::CFG_REGISTER_COUNT, pick_word());
        upper = 8'($urandom);
        cfg_write(mbrf_pkg::CFG_LAST_SLAVE, {upper, pick_last_slave()});
    endtask

    initial begin
        int phase;
        int len;
        phase = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults: wrap after slave six, idle polls mixed in.
        queue_polls(16'b1_0111_1110, 9);
        wait_drained();

        // Extremes; a last slave of zero acts as one.
        cfg_write(mbrf_pkg::CFG_FUNCTION_CODE, 16'h5AFF);
        cfg_write(mbrf_pkg::CFG_START_ADDRESS, 16'hFFFF);
        cfg_write(mbrf_pkg::CFG_REGISTER_COUNT, 16'h0000);
        cfg_write(mbrf_pkg::CFG_LAST_SLAVE, 16'hFF00);
        queue_polls(16'b11, 2);
        wait_drained();

        // Opposite extremes; a last slave above the Modbus maximum acts as 247.
        cfg_write(mbrf_pkg::CFG_FUNCTION_CODE, 16'hA500);
        cfg_write(mbrf_pkg::CFG_START_ADDRESS, 16'h0000);
        cfg_write(mbrf_pkg::CFG_REGISTER_COUNT, 16'hFFFF);
        cfg_write(mbrf_pkg::CFG_LAST_SLAVE, 16'h12FF);
        queue_polls(16'b111, 3);
        wait_drained();

        // Set the last slave to six, then below the counter to two so that a frame restarts at one.
        cfg_write(mbrf_pkg::CFG_LAST_SLAVE, 16'd6);
        queue_polls(16'b1, 1);
        wait_drained();
        cfg_write(mbrf_pkg::CFG_LAST_SLAVE, 16'd2);
        queue_polls(16'b11, 2);
        wait_drained();

        while (items_queued < 110) begin
            random_settings();
            sender_eager = (phase == 1 || phase == 2);
            rx_eager = (phase == 2);
            if (phase == 1 || phase == 5)
                hold_requests++;
            len = $urandom_range(10, 18);
            for (int i = 0; i < len; i++) begin
                polls_pending.push_back($urandom_range(0, 99) < 80);
                items_queued++;
            end
            wait_drained();
            phase++;
        end

        repeat (12) @(negedge i_clk);
        if (frame_bytes_due.size() != 0)
            report_mismatch("bytes never sent", 8'(frame_bytes_due.size()), 8'h00);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
